/* hdl/assert_macros.svh */
// Assertion helpers for the sprite decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PRSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define PRSD_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");
`else
`define PRSD_ASSERT(lbl, clk, rstn, prop)
`define PRSD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hdl/prsd_pkg.sv */
package prsd_pkg;

	localparam logic [15:0] CAP_RESET = 16'd6144;

	typedef enum logic [1:0] {
		KIND_PAL   = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_slot;
		logic [15:0] wr_colour;
		logic        rd_en;
		logic [3:0]  rd_slot;
	} pal_ctrl_t;

endpackage

/* hdl/prsd_if.sv */
interface prsd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  palette_slot;
	logic [15:0] palette_colour;
	logic [15:0] declared_length;
	logic [15:0] available_bytes;
	logic [7:0]  data_byte;

	modport source (output valid, kind, palette_slot, palette_colour, declared_length,
		available_bytes, data_byte, input ready);
	modport sink (input valid, kind, palette_slot, palette_colour, declared_length,
		available_bytes, data_byte, output ready);
endinterface

interface prsd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_colour;
	logic [15:0] pixel_position;
	logic        run_end;
	logic        error;

	modport source (output valid, pixel_colour, pixel_position, run_end, error,
		input ready);
	modport sink (input valid, pixel_colour, pixel_position, run_end, error,
		output ready);
endinterface

interface prsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hdl/prsd_palette.sv */
module prsd_palette
	import prsd_pkg::*;
(
	input  logic        clk,
	input  pal_ctrl_t   ctrl,
	output logic [15:0] rd_data
);

	logic [15:0] mem [16];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_slot] <= ctrl.wr_colour;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[ctrl.rd_slot];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/prsd_seq.sv */
module prsd_seq
	import prsd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	prsd_in_if.sink         in_ch,
	prsd_out_if.source      out_ch,
	input  logic [15:0]     capacity,
	output pal_ctrl_t       pal_ctrl,
	input  logic [15:0]     pal_rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_FAULT
	} state_t;

	state_t      state_q;
	logic [15:0] cursor_q;
	logic [15:0] remain_q;
	logic        failed_q;
	logic [3:0]  run_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	logic [15:0] colour_q;
	logic [15:0] pos_q;
	logic        end_q;
	logic        err_q;

	logic accept;
	logic slot_free;
	logic emit;
	logic over;
	logic last;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;
	assign emit        = slot_free && ((state_q == S_EMIT) || (state_q == S_FAULT));
	// shared compare/increment unit: one pixel per step
	assign over        = (cursor_q >= capacity);
	assign last        = ((cnt_q + 4'd1) == run_q);

	always_comb begin
		pal_ctrl.wr_en     = accept && (in_ch.kind == KIND_PAL);
		pal_ctrl.wr_slot   = in_ch.palette_slot;
		pal_ctrl.wr_colour = in_ch.palette_colour;
		pal_ctrl.rd_en     = accept && (in_ch.kind == KIND_DATA);
		pal_ctrl.rd_slot   = in_ch.data_byte[7:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			remain_q    <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind_t'(in_ch.kind))
							KIND_FRAME: begin
								cursor_q <= '0;
								if (in_ch.declared_length > in_ch.available_bytes) begin
									failed_q <= 1'b1;
									remain_q <= '0;
									state_q  <= S_FAULT;
								end else begin
									failed_q <= 1'b0;
									remain_q <= in_ch.declared_length;
								end
							end
							KIND_DATA: begin
								if (!failed_q && (remain_q != 16'd0)) begin
									remain_q <= remain_q - 16'd1;
									run_q    <= in_ch.data_byte[3:0];
									cnt_q    <= '0;
									if (in_ch.data_byte[3:0] != 4'd0) begin
										state_q <= S_EMIT;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (over) begin
							colour_q <= '0;
							pos_q    <= '0;
							end_q    <= 1'b1;
							err_q    <= 1'b1;
							failed_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							colour_q <= pal_rd_data;
							pos_q    <= cursor_q;
							end_q    <= last;
							err_q    <= 1'b0;
							cursor_q <= cursor_q + 16'd1;
							cnt_q    <= cnt_q + 4'd1;
							if (last) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_FAULT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						colour_q    <= '0;
						pos_q       <= '0;
						end_q       <= 1'b1;
						err_q       <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.pixel_colour   = colour_q;
	assign out_ch.pixel_position = pos_q;
	assign out_ch.run_end        = end_q;
	assign out_ch.error          = err_q;

endmodule

/* hdl/palette_rle_sprite_decoder_top.sv */
// Run-length sprite decoder with a 16-entry palette of 16-bit colors.
// Channels: in_ch takes palette writes, frame starts and data bytes; out_ch
// delivers one pixel (color, position, run end, error) per transaction; cfg
// writes the pixel capacity and is always ready.
// Palette writes and frame starts are taken while idle; a frame start with a
// length mismatch goes to the fault state, which loads its error result. A
// data byte with run length N reads its palette entry as it is accepted, then
// yields N pixels, or stops with an error once the cursor reaches capacity;
// the emit state loads each pixel into the output register through one shared
// cursor compare/increment step, one pixel per cycle unless out_ch stalls.
// in_ch.ready is high only while the sequencer is idle; it may take the next
// item while the last result of the previous one still sits in the output
// register.
// A stall on out_ch holds the output register and the sequencer waits while
// it lasts; no result is dropped.
// Reset clears the cursor, remaining byte count and fail flag, empties the
// output register and sets the capacity to 6144. Palette contents are
// undefined until written.
`include "assert_macros.svh"

module palette_rle_sprite_decoder_top
	import prsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	prsd_in_if.sink     in_ch,
	prsd_out_if.source  out_ch,
	prsd_cfg_if.sink    cfg
);

	logic [15:0] capacity_q;
	pal_ctrl_t   pal_ctrl;
	logic [15:0] pal_rd_data;
	logic        err_zero;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.data;
		end
	end

	prsd_palette u_palette (
		.clk     (clk),
		.ctrl    (pal_ctrl),
		.rd_data (pal_rd_data)
	);

	prsd_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.capacity    (capacity_q),
		.pal_ctrl    (pal_ctrl),
		.pal_rd_data (pal_rd_data)
	);

	assign err_zero = (out_ch.pixel_colour == 16'd0) && (out_ch.pixel_position == 16'd0)
		&& out_ch.run_end;

	`PRSD_ASSERT(a_err_payload, clk, arst_n, (out_ch.valid && out_ch.error) |-> err_zero)
	`PRSD_NEVER(a_idle_mid_run, clk, arst_n, in_ch.ready && out_ch.valid && !out_ch.run_end)
	`PRSD_NEVER(a_pal_rw_clash, clk, arst_n, pal_ctrl.wr_en && pal_ctrl.rd_en)

endmodule

/* tb/sv/prsd_checker.sv */
module prsd_checker
	import prsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic [3:0]  in_palette_slot,
	input  logic [15:0] in_palette_colour,
	input  logic [15:0] in_declared_length,
	input  logic [15:0] in_available_bytes,
	input  logic [7:0]  in_data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_pixel_colour,
	input  logic [15:0] out_pixel_position,
	input  logic        out_run_end,
	input  logic        out_error,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [15:0] colour;
		logic [15:0] position;
		logic        last;
		logic        err;
	} pixel_t;

	pixel_t      expected_pixels[$];
	logic [15:0] palette [16];
	logic [15:0] cursor;
	logic [15:0] bytes_left;
	logic [15:0] capacity;
	logic        blocked;

	task automatic report(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic push_pixel(input logic [15:0] colour, input logic [15:0] position,
		input logic last, input logic err);
		pixel_t p;
		p.colour = colour;
		p.position = position;
		p.last = last;
		p.err = err;
		expected_pixels.push_back(p);
	endtask

	task automatic decode_item();
		logic [3:0] idx;
		int         run;
		case (in_kind)
			KIND_PAL: begin
				palette[in_palette_slot] = in_palette_colour;
			end
			KIND_FRAME: begin
				cursor = '0;
				if (in_declared_length > in_available_bytes) begin
					blocked = 1'b1;
					bytes_left = '0;
					push_pixel(16'h0, 16'h0, 1'b1, 1'b1);
				end else begin
					blocked = 1'b0;
					bytes_left = in_declared_length;
				end
			end
			KIND_DATA: begin
				if (!blocked && bytes_left != 0) begin
					bytes_left = bytes_left - 16'd1;
					idx = in_data_byte[7:4];
					run = in_data_byte[3:0];
					for (int j = 0; j < run; j++) begin
						if (cursor >= capacity) begin
							blocked = 1'b1;
							push_pixel(16'h0, 16'h0, 1'b1, 1'b1);
							break;
						end
						push_pixel(palette[idx], cursor, (j + 1 == run), 1'b0);
						cursor = cursor + 16'd1;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report($sformatf("unexpected result colour %h position %h run_end %b error %b",
				out_pixel_colour, out_pixel_position, out_run_end, out_error));
		end else begin
			want = expected_pixels.pop_front();
			if (out_pixel_colour !== want.colour)
				report($sformatf("pixel_colour got %h expected %h at position %h",
					out_pixel_colour, want.colour, want.position));
			if (out_pixel_position !== want.position)
				report($sformatf("pixel_position got %h expected %h",
					out_pixel_position, want.position));
			if (out_run_end !== want.last)
				report($sformatf("run_end got %b expected %b at position %h",
					out_run_end, want.last, want.position));
			if (out_error !== want.err)
				report($sformatf("error got %b expected %b at position %h",
					out_error, want.err, want.position));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor = '0;
			bytes_left = '0;
			blocked = 1'b0;
			capacity = CAP_RESET;
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (in_valid && in_ready)
				decode_item();
			if (out_valid && out_ready)
				check_pixel();
			outstanding <= expected_pixels.size();
		end
	end

endmodule

/* tb/sv/tb_palette_rle_sprite_decoder_top.sv */
module tb_palette_rle_sprite_decoder_top;
	import prsd_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	int   burst_left = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_phase = 0;

	prsd_in_if  in_ch ();
	prsd_out_if out_ch ();
	prsd_cfg_if cfg_ch ();

	palette_rle_sprite_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	prsd_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_ch.valid),
		.in_ready           (in_ch.ready),
		.in_kind            (in_ch.kind),
		.in_palette_slot    (in_ch.palette_slot),
		.in_palette_colour  (in_ch.palette_colour),
		.in_declared_length (in_ch.declared_length),
		.in_available_bytes (in_ch.available_bytes),
		.in_data_byte       (in_ch.data_byte),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.out_pixel_colour   (out_ch.pixel_colour),
		.out_pixel_position (out_ch.pixel_position),
		.out_run_end        (out_ch.run_end),
		.out_error          (out_ch.error),
		.cfg_valid          (cfg_ch.valid),
		.cfg_ready          (cfg_ch.ready),
		.cfg_data           (cfg_ch.data),
		.mismatches         (mismatches),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			rx_phase++;
			case (rx_mode)
				RX_OPEN:   out_ch.ready <= 1'b1;
				RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   out_ch.ready <= (rx_phase % 5 != 4);
			endcase
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [3:0] slot,
		input logic [15:0] colour, input logic [15:0] decl, input logic [15:0] avail,
		input logic [7:0] data_val);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
			gap = $urandom_range(1, 8);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.palette_slot <= slot;
		in_ch.palette_colour <= colour;
		in_ch.declared_length <= decl;
		in_ch.available_bytes <= avail;
		in_ch.data_byte <= data_val;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_palette(input logic [3:0] slot, input logic [15:0] colour);
		send_item(KIND_PAL, slot, colour, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic send_frame(input logic [15:0] decl, input logic [15:0] avail);
		send_item(KIND_FRAME, 4'($urandom), 16'($urandom), decl, avail, 8'($urandom));
	endtask

	task automatic send_data(input logic [7:0] data_val);
		send_item(KIND_DATA, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			data_val);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_items(input int count);
		int sent;
		int pick;
		int decl;
		int avail;
		int n;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				decl = $urandom_range(1, 10);
				if ($urandom_range(0, 4) == 0)
					avail = $urandom_range(decl, 65535);
				else
					avail = decl + $urandom_range(0, 5);
				send_frame(16'(decl), 16'(avail));
				sent++;
				for (int k = 0; k < decl; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_palette(4'($urandom), 16'($urandom));
						sent++;
					end
					send_data(8'($urandom));
					sent++;
				end
				if ($urandom_range(0, 4) == 0) begin
					n = $urandom_range(1, 3);
					repeat (n) send_data(8'($urandom));
				end
			end else if (pick < 80) begin
				decl = $urandom_range(0, 65535);
				avail = $urandom_range(decl, 65535);
				send_frame(16'(decl), 16'(avail));
				sent++;
				n = $urandom_range(1, 6);
				repeat (n) begin
					send_data(8'($urandom));
					sent++;
				end
			end else if (pick < 88) begin
				avail = $urandom_range(0, 65534);
				decl = $urandom_range(avail + 1, 65535);
				send_frame(16'(decl), 16'(avail));
				sent++;
				n = $urandom_range(1, 3);
				repeat (n) send_data(8'($urandom));
			end else if (pick < 94) begin
				send_palette(4'($urandom), 16'($urandom));
				sent++;
			end else if (pick < 97) begin
				send_item(KIND_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			end else begin
				wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_PAL;
		in_ch.palette_slot <= '0;
		in_ch.palette_colour <= '0;
		in_ch.declared_length <= '0;
		in_ch.available_bytes <= '0;
		in_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole palette first so no read hits an unwritten entry
		for (int s = 0; s < 16; s++) begin
			if (s == 0)
				send_palette(4'(s), 16'h0000);
			else if (s == 15)
				send_palette(4'(s), 16'hffff);
			else
				send_palette(4'(s), 16'($urandom));
		end
		send_data(8'h12);                      // before any frame start
		send_item(KIND_NONE, 4'hf, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		send_frame(16'hffff, 16'hfffe);        // length mismatch
		send_data(8'hf5);                      // ignored while blocked
		send_frame(16'd4, 16'd4);
		send_data(8'h00);                      // empty run
		send_data(8'hff);
		send_data(8'h01);
		send_frame(16'hffff, 16'hffff);        // restart mid-frame
		send_data(8'ha7);
		send_frame(16'd0, 16'd0);
		send_data(8'h33);                      // length used up
		send_frame(16'd1, 16'd1);
		send_data(8'h5c);
		send_data(8'h6e);                      // beyond declared length

		write_capacity(16'd0);
		send_frame(16'd2, 16'd2);
		send_data(8'h3a);                      // overflow at first pixel
		send_data(8'h49);

		write_capacity(16'hffff);
		random_items(70);
		write_capacity(16'($urandom_range(8, 60)));
		random_items(60);
		write_capacity(16'($urandom));
		random_items(50);
		write_capacity(16'd1);
		random_items(20);
		wait_drained();

		if (outstanding != 0)
			$display("ERROR: %0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
